// ----- src/dwarf_encoded_value_decoder_assert.svh -----
// ---------------------------------------------------------------------------
// DWARF encoded-value decoder assertion macros
// Implication checks on the rising clock edge, disabled while in reset.
// ---------------------------------------------------------------------------
`ifndef DWARF_ENCODED_VALUE_DECODER_ASSERT_SVH
`define DWARF_ENCODED_VALUE_DECODER_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication.
`define DWEV_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dwev assertion failed: same-cycle implication");

// Next-cycle implication.
`define DWEV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dwev assertion failed: next-cycle implication");

`else

`define DWEV_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DWEV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- src/dwev_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dwev_pkg
// Types, format codes and helper functions shared by the decoder modules.
// ---------------------------------------------------------------------------
package dwev_pkg;

    localparam int VALUE_WIDTH = 64;   // result width before extension, 32..64
    localparam int ACC_W       = 64;

    // Low nibble of the pointer-encoding code
    localparam logic [3:0] FMT_OMIT   = 4'h0;
    localparam logic [3:0] FMT_ULEB   = 4'h1;
    localparam logic [3:0] FMT_UDATA2 = 4'h2;
    localparam logic [3:0] FMT_UDATA4 = 4'h3;
    localparam logic [3:0] FMT_UDATA8 = 4'h4;
    localparam logic [3:0] FMT_SLEB   = 4'h9;
    localparam logic [3:0] FMT_SDATA2 = 4'hA;
    localparam logic [3:0] FMT_SDATA4 = 4'hB;
    localparam logic [3:0] FMT_SDATA8 = 4'hC;

    localparam logic [2:0] FORM_LEB   = 3'd1;
    localparam logic [2:0] FORM_DATA2 = 3'd2;
    localparam logic [2:0] FORM_DATA4 = 3'd3;

    localparam logic [6:0] LEB_SHIFT_CAP = 7'd70;
    localparam logic [6:0] LEB_STEP      = 7'd7;
    localparam int         LEB_CONT_BIT  = 7;
    localparam int         LEB_SIGN_BIT  = 6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] encoding;
    } in_word_t;

    typedef struct packed {
        logic [63:0] value;
        logic        error;
        logic        byte_consumed;
    } out_word_t;

    typedef struct packed {
        logic has_result;
        logic busy;
    } step_status_t;

    function automatic logic known_code(input logic [3:0] c);
        known_code = (c == FMT_ULEB)   || (c == FMT_UDATA2) || (c == FMT_UDATA4) ||
                     (c == FMT_UDATA8) || (c == FMT_SLEB)   || (c == FMT_SDATA2) ||
                     (c == FMT_SDATA4) || (c == FMT_SDATA8);
    endfunction

    // Cut to VALUE_WIDTH, then sign or zero extend back to 64 bits.
    function automatic logic [63:0] finish_value(input logic [ACC_W-1:0] v,
                                                 input logic is_signed);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (i < VALUE_WIDTH)
                r[i] = v[i];
            else
                r[i] = is_signed & v[VALUE_WIDTH-1];
        end
        return r;
    endfunction

endpackage

// ----- src/dwarf_encoded_value_decoder.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dwarf_encoded_value_decoder
// Decode DWARF pointer-encoded values and LEB128 from a byte stream.
// ---------------------------------------------------------------------------
// Usage:
//   stream_* carries one encoded byte per word plus the pointer-encoding
//   code; the code is only looked at when no value is in progress.
//   result_* carries one word per finished value, per omit code (value 0)
//   and per unknown code (error set); omit and error leave the byte unused,
//   so the sender must present that byte again as the start of a value.
//   Bytes in the middle of a value produce no result word.
// Timing:
//   A word is accepted at an edge where valid is high and stall is low.
//   The input register feeds the decode step, whose result lands in the
//   output register. One byte per cycle is sustained while result_stall
//   holds no waiting result, set by the combinational shift-and-OR step
//   into the accumulator.
// Reset:
//   rst_n clears both register valids and returns the decoder to idle.
// Stall:
//   When result_stall holds a waiting result, the decode step freezes and
//   the input register holds its byte; stream_stall rises only then.
// ---------------------------------------------------------------------------
`include "dwarf_encoded_value_decoder_assert.svh"

module dwarf_encoded_value_decoder
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                stream_valid,
    output logic                stream_stall,
    input  dwev_pkg::in_word_t  stream_word,
    output logic                result_valid,
    input  logic                result_stall,
    output dwev_pkg::out_word_t result_word
);

    logic                   stage_vld_reg, stage_vld_next;
    dwev_pkg::in_word_t     stage_reg;
    logic                   out_vld_reg, out_vld_next;
    dwev_pkg::out_word_t    out_reg;

    logic                   advance, fire, load_out;
    dwev_pkg::out_word_t    step_result;
    dwev_pkg::step_status_t step_status;

    // Advance the step whenever the output register is free or being drained
    assign advance  = !out_vld_reg || !result_stall;
    assign fire     = stage_vld_reg && advance;
    assign load_out = fire && step_status.has_result;

    // Hold the input register only while the step is frozen
    assign stream_stall = stage_vld_reg && !advance;

    always_comb
    begin
        stage_vld_next = stage_vld_reg;
        if (!stream_stall)
            stage_vld_next = stream_valid;

        out_vld_next = out_vld_reg;
        if (advance)
            out_vld_next = load_out;
    end

    dwev_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .word   (stage_reg),
        .result (step_result),
        .status (step_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_vld_reg <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            stage_vld_reg <= stage_vld_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        if (stream_valid && !stream_stall)
            stage_reg <= stream_word;
        if (load_out)
            out_reg <= step_result;
    end

    assign result_valid = out_vld_reg;
    assign result_word  = out_reg;

    `DWEV_ASSERT_IMP(a_stall_only_when_full, clk, rst_n, stream_stall, stage_vld_reg)
    `DWEV_ASSERT_IMP(a_error_shape, clk, rst_n,
        result_valid && result_word.error,
        (result_word.value == 64'd0) && !result_word.byte_consumed)
    `DWEV_ASSERT_NEXT(a_done_goes_idle, clk, rst_n,
        load_out && step_result.byte_consumed, !step_status.busy)
    `DWEV_ASSERT_NEXT(a_frozen_holds_stage, clk, rst_n,
        stage_vld_reg && !advance, stage_vld_reg && $stable(stage_reg))

endmodule

// ----- src/dwev_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dwev_core
// Decode state and the one-byte step: LEB128 and fixed-size forms.
// ---------------------------------------------------------------------------
module dwev_core
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  dwev_pkg::in_word_t    word,
    output dwev_pkg::out_word_t   result,
    output dwev_pkg::step_status_t status
);

    logic                      busy_reg, busy_next;
    logic [3:0]                fmt_reg, fmt_next;
    logic [dwev_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic [6:0]                shift_reg, shift_next;
    logic [2:0]                seen_reg, seen_next;

    logic [3:0]                code_in, code;
    logic                      start, omit, bad, is_signed, is_leb, done;
    logic [dwev_pkg::ACC_W-1:0] acc0, acc_leb, acc_fix, acc_new;
    logic [6:0]                sh0, sh_new;
    logic [7:0]                sh_sum;
    logic [2:0]                seen0, seen_new, n_len;
    logic                      leb_done, fix_done;
    logic [7:0]                b;

    always_comb
    begin
        b       = word.data_byte;
        code_in = word.encoding[3:0];
        start   = !busy_reg;
        omit    = start && (code_in == dwev_pkg::FMT_OMIT);
        bad     = start && !omit && !dwev_pkg::known_code(code_in);

        code  = start ? code_in : fmt_reg;
        acc0  = start ? '0 : acc_reg;
        sh0   = start ? '0 : shift_reg;
        seen0 = start ? '0 : seen_reg;

        is_signed = code[3];
        is_leb    = (code[2:0] == dwev_pkg::FORM_LEB);

        // LEB128: OR in seven payload bits, drop anything at bit 64 or above
        acc_leb = acc0;
        if (!sh0[6])
            acc_leb = acc_leb | ({57'b0, b[6:0]} << sh0[5:0]);
        sh_sum = {1'b0, sh0} + {1'b0, dwev_pkg::LEB_STEP};
        sh_new = (sh_sum > {1'b0, dwev_pkg::LEB_SHIFT_CAP}) ?
                 dwev_pkg::LEB_SHIFT_CAP : sh_sum[6:0];
        leb_done = !b[dwev_pkg::LEB_CONT_BIT];
        if (leb_done && is_signed && b[dwev_pkg::LEB_SIGN_BIT] && !sh_new[6])
            acc_leb = acc_leb | ({dwev_pkg::ACC_W{1'b1}} << sh_new[5:0]);

        // Fixed-size little-endian forms
        case (code[2:0])
            dwev_pkg::FORM_DATA2: n_len = 3'd2;
            dwev_pkg::FORM_DATA4: n_len = 3'd4;
            default:              n_len = 3'd0;   // eight bytes, count wraps
        endcase
        acc_fix  = acc0 | ({56'b0, b} << {seen0, 3'b000});
        seen_new = seen0 + 3'd1;
        fix_done = (seen_new == n_len);
        if (fix_done && is_signed)
        begin
            if (n_len == 3'd2 && acc_fix[15])
                acc_fix[63:16] = '1;
            else if (n_len == 3'd4 && acc_fix[31])
                acc_fix[63:32] = '1;
        end

        done    = is_leb ? leb_done : fix_done;
        acc_new = is_leb ? acc_leb : acc_fix;

        result = '0;
        if (bad)
            result.error = 1'b1;
        else if (!omit)
        begin
            result.value         = dwev_pkg::finish_value(acc_new, is_signed);
            result.byte_consumed = 1'b1;
        end

        status.has_result = omit || bad || done;
        status.busy       = busy_reg;

        busy_next  = busy_reg;
        fmt_next   = fmt_reg;
        acc_next   = acc_reg;
        shift_next = shift_reg;
        seen_next  = seen_reg;
        if (fire && !omit && !bad)
        begin
            if (done)
            begin
                busy_next  = 1'b0;
                fmt_next   = dwev_pkg::FMT_OMIT;
                acc_next   = '0;
                shift_next = '0;
                seen_next  = '0;
            end
            else
            begin
                busy_next  = 1'b1;
                fmt_next   = code;
                acc_next   = acc_new;
                shift_next = is_leb ? sh_new : sh0;
                seen_next  = is_leb ? seen0 : seen_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            fmt_reg   <= dwev_pkg::FMT_OMIT;
            acc_reg   <= '0;
            shift_reg <= '0;
            seen_reg  <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            fmt_reg   <= fmt_next;
            acc_reg   <= acc_next;
            shift_reg <= shift_next;
            seen_reg  <= seen_next;
        end
    end

endmodule

// ----- verif/tb_dwarf_encoded_value_decoder.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_dwarf_encoded_value_decoder
// Self-checking bench for the DWARF encoded-value decoder. A short directed
// run covers omit, every unknown nibble and the edges of the LEB and fixed
// forms. Random values follow, most of them well-formed and some of them
// noise. Both sides idle at random. A scoreboard predicts each result word
// from the accepted stream words and compares every field of each result.
// ---------------------------------------------------------------------------
module tb_dwarf_encoded_value_decoder;

    localparam int CLK_HALF    = 5;
    localparam int RANDOM_WORDS = 1050;
    localparam int MAX_WAIT    = 18;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_MAX  = 10;

    // Nibbles that the decoder treats as unknown formats
    localparam logic [3:0] UNKNOWN_NIBBLES [7] =
        '{4'h5, 4'h6, 4'h7, 4'h8, 4'hD, 4'hE, 4'hF};
    localparam logic [3:0] KNOWN_FORMATS [8] =
        '{dwev_pkg::FMT_ULEB, dwev_pkg::FMT_UDATA2, dwev_pkg::FMT_UDATA4,
          dwev_pkg::FMT_UDATA8, dwev_pkg::FMT_SLEB, dwev_pkg::FMT_SDATA2,
          dwev_pkg::FMT_SDATA4, dwev_pkg::FMT_SDATA8};

    // -----------------------------------------------------------------------
    // Scoreboard: tracks the decoder state and holds the expected results
    // -----------------------------------------------------------------------
    class decoded_value_scoreboard;
        dwev_pkg::out_word_t expected_values[$];
        bit          in_value;
        logic [3:0]  value_format;
        logic [63:0] gathered;
        int          leb_shift;
        int          fixed_count;
        int          failures;

        function new();
            in_value     = 1'b0;
            value_format = dwev_pkg::FMT_OMIT;
            gathered     = '0;
            leb_shift    = 0;
            fixed_count  = 0;
            failures     = 0;
        endfunction

        function bit format_known(logic [3:0] code);
            case (code)
                dwev_pkg::FMT_ULEB, dwev_pkg::FMT_UDATA2, dwev_pkg::FMT_UDATA4,
                dwev_pkg::FMT_UDATA8, dwev_pkg::FMT_SLEB, dwev_pkg::FMT_SDATA2,
                dwev_pkg::FMT_SDATA4, dwev_pkg::FMT_SDATA8: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        // Cut to VALUE_WIDTH bits, then extend to 64 by the form's sign.
        function logic [63:0] fit_width(logic [63:0] v, bit is_signed);
            logic [63:0] keep;
            keep = (dwev_pkg::VALUE_WIDTH >= 64) ? '1 :
                   ((64'd1 << dwev_pkg::VALUE_WIDTH) - 64'd1);
            v = v & keep;
            if (is_signed && dwev_pkg::VALUE_WIDTH < 64 && v[dwev_pkg::VALUE_WIDTH-1])
                v = v | ~keep;
            return v;
        endfunction

        // Advance the predicted decoder state by one accepted stream word.
        function void note_stream_word(dwev_pkg::in_word_t w);
            dwev_pkg::out_word_t res;
            logic [3:0]  code;
            bit          is_signed;
            bit          done;
            int          n;
            done = 1'b0;
            if (!in_value)
            begin
                code = w.encoding[3:0];
                if (code == dwev_pkg::FMT_OMIT || !format_known(code))
                begin
                    // Answer at once and leave the byte unused
                    res.value         = '0;
                    res.error         = (code != dwev_pkg::FMT_OMIT);
                    res.byte_consumed = 1'b0;
                    expected_values.push_back(res);
                    return;
                end
                in_value     = 1'b1;
                value_format = code;
                gathered     = '0;
                leb_shift    = 0;
                fixed_count  = 0;
            end
            is_signed = value_format[3];
            if (value_format[2:0] == dwev_pkg::FORM_LEB)
            begin
                if (leb_shift < 64)
                    gathered = gathered | (64'(w.data_byte[6:0]) << leb_shift);
                leb_shift = leb_shift + int'(dwev_pkg::LEB_STEP);
                if (leb_shift > int'(dwev_pkg::LEB_SHIFT_CAP))
                    leb_shift = int'(dwev_pkg::LEB_SHIFT_CAP);
                if (!w.data_byte[dwev_pkg::LEB_CONT_BIT])
                begin
                    if (is_signed && w.data_byte[dwev_pkg::LEB_SIGN_BIT] && leb_shift < 64)
                        gathered = gathered | (~64'd0 << leb_shift);
                    done = 1'b1;
                end
            end
            else
            begin
                n = (value_format[2:0] == dwev_pkg::FORM_DATA2) ? 2 :
                    (value_format[2:0] == dwev_pkg::FORM_DATA4) ? 4 : 8;
                gathered = gathered | (64'(w.data_byte) << (8 * fixed_count));
                fixed_count++;
                if (fixed_count == n)
                begin
                    if (is_signed && n < 8 && gathered[8*n-1])
                        gathered = gathered | (~64'd0 << (8 * n));
                    done = 1'b1;
                end
            end
            if (done)
            begin
                res.value         = fit_width(gathered, is_signed);
                res.error         = 1'b0;
                res.byte_consumed = 1'b1;
                expected_values.push_back(res);
                in_value = 1'b0;
            end
        endfunction

        function void report(string what, dwev_pkg::out_word_t want,
                             dwev_pkg::out_word_t got);
            failures++;
            if (failures <= REPORT_MAX)
                $display("%0t: %s: expected value=%h error=%b used=%b, %s",
                         $time, what, want.value, want.error, want.byte_consumed,
                         $sformatf("got value=%h error=%b used=%b",
                                   got.value, got.error, got.byte_consumed));
        endfunction

        function void check_result_word(dwev_pkg::out_word_t got);
            dwev_pkg::out_word_t want;
            if (expected_values.size() == 0)
            begin
                report("unexpected result", '0, got);
                return;
            end
            want = expected_values.pop_front();
            if (got.value !== want.value || got.error !== want.error ||
                got.byte_consumed !== want.byte_consumed)
                report("result mismatch", want, got);
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // Clock, reset and the block
    // -----------------------------------------------------------------------
    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                stream_valid = 1'b0;
    logic                stream_stall;
    dwev_pkg::in_word_t  stream_word  = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    dwev_pkg::out_word_t result_word;

    decoded_value_scoreboard board = new();
    int words_sent   = 0;
    int cycle_count  = 0;
    bit sender_burst = 1'b0;
    bit taker_burst  = 1'b0;

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    dwarf_encoded_value_decoder u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .stream_valid (stream_valid),
        .stream_stall (stream_stall),
        .stream_word  (stream_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word)
    );

    // Bail out if the run hangs; the limit is far above the slowest good run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_dwarf_encoded_value_decoder: FAIL");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Stream side
    // -----------------------------------------------------------------------
    // Pick an idle gap for the next word; flip now and then into a burst
    // stretch with no idling at all.
    function automatic int draw_wait(ref bit burst);
        if ($urandom_range(0, 31) == 0)
            burst = !burst;
        return burst ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // Present one word and hold it until the block takes it. Called at a
    // rising edge; valid is only lowered when a gap follows.
    task automatic send_word(input logic [7:0] enc, input logic [7:0] data);
        dwev_pkg::in_word_t w;
        int                 gap;
        w.encoding  = enc;
        w.data_byte = data;
        gap = draw_wait(sender_burst);
        if (gap > 0)
        begin
            stream_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        stream_valid <= 1'b1;
        stream_word  <= w;
        // Stall is settled by the falling edge; decide acceptance there.
        @(negedge clk);
        while (stream_stall)
            @(negedge clk);
        @(posedge clk);
        board.note_stream_word(w);
        words_sent++;
    endtask

    // One random value: mostly well-formed, with omit, unknown and noise words.
    task automatic send_random_value();
        int         pick;
        int         len;
        logic [3:0] code;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            send_word({4'($urandom), dwev_pkg::FMT_OMIT}, 8'($urandom));
        else if (pick < 10)
            send_word({4'($urandom), UNKNOWN_NIBBLES[$urandom_range(0, 6)]},
                      8'($urandom));
        else if (pick < 15)
            send_word(8'($urandom), 8'($urandom));
        else
        begin
            code = KNOWN_FORMATS[$urandom_range(0, 7)];
            if (code[2:0] == dwev_pkg::FORM_LEB)
            begin
                // Mostly short runs; some long ones push past 64 bits.
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 13)
                                                  : $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                begin
                    case ($urandom_range(0, 5))
                        0: b = 8'h7F;
                        1: b = 8'h00;
                        default: b = 8'($urandom);
                    endcase
                    b[dwev_pkg::LEB_CONT_BIT] = (i != len - 1);
                    send_word(i == 0 ? {4'($urandom), code} : 8'($urandom), b);
                end
            end
            else
            begin
                len = (code[2:0] == dwev_pkg::FORM_DATA2) ? 2 :
                      (code[2:0] == dwev_pkg::FORM_DATA4) ? 4 : 8;
                for (int i = 0; i < len; i++)
                    send_word(i == 0 ? {4'($urandom), code} : 8'($urandom),
                              8'($urandom));
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Omit with the high nibble set; the byte is left unused
        send_word({4'hF, dwev_pkg::FMT_OMIT}, 8'hFF);
        // Every unknown nibble, each with a different high nibble
        for (int i = 0; i < 7; i++)
            send_word({4'(i * 2 + 1), UNKNOWN_NIBBLES[i]}, 8'h5A);
        // Single-byte LEB: largest unsigned, most negative signed
        send_word({4'hE, dwev_pkg::FMT_ULEB}, 8'h7F);
        send_word({4'h0, dwev_pkg::FMT_SLEB}, 8'h40);
        // Two-byte signed LEB ending in a set sign bit
        send_word({4'h3, dwev_pkg::FMT_SLEB}, 8'h80);
        send_word({4'h0, dwev_pkg::FMT_OMIT}, 8'h7F);
        // Fixed forms: sign bit at the top, all ones, omit nibble mid-value
        send_word({4'h8, dwev_pkg::FMT_SDATA2}, 8'h00);
        send_word({4'h0, dwev_pkg::FMT_OMIT}, 8'h80);
        send_word({4'h0, dwev_pkg::FMT_UDATA4}, 8'hFF);
        repeat (3) send_word({4'hF, UNKNOWN_NIBBLES[0]}, 8'hFF);
        send_word({4'h5, dwev_pkg::FMT_SDATA4}, 8'h00);
        repeat (2) send_word(8'hFF, 8'h00);
        send_word(8'h00, 8'h80);

        while (words_sent < RANDOM_WORDS)
            send_random_value();
        stream_valid <= 1'b0;

        // Drain, then give stray results a chance to show up.
        while (board.expected_values.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.failures == 0 && board.expected_values.size() == 0)
            $display("tb_dwarf_encoded_value_decoder: PASS");
        else
            $display("tb_dwarf_encoded_value_decoder: FAIL");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Result side: take a word, check it, then stall for a random while
    // -----------------------------------------------------------------------
    initial
    begin
        dwev_pkg::out_word_t got;
        int                  hold;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (result_valid === 1'b1 && !result_stall)
            begin
                got = result_word;
                @(posedge clk);
                board.check_result_word(got);
                hold = draw_wait(taker_burst);
                if (hold > 0)
                begin
                    result_stall <= 1'b1;
                    repeat (hold) @(posedge clk);
                    result_stall <= 1'b0;
                end
            end
        end
    end

endmodule

// ----- dwarf_encoded_value_decoder.f -----
+incdir+src
src/dwev_pkg.sv
src/dwev_core.sv
src/dwarf_encoded_value_decoder.sv
verif/tb_dwarf_encoded_value_decoder.sv
